// ----- rtl/core/s3tc_pkg.sv -----
// Shared types, codes and constant-divide helpers for the S3TC block decoder.
package s3tc_pkg;

  localparam int DIM_W = 14;
  localparam int CRD_W = 13;
  localparam int CH_W = 8;
  localparam int DEF_MAX_DIMENSION = 8192;
  localparam logic [DIM_W-1:0] DEF_DIM = 14'd256;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_RSVD = 2'd3   // decodes as DXT1
  } fmt_t;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [63:0]      lo;
    logic [63:0]      hi;
    fmt_t             fmt;
    logic [15:0]      mask;
    logic [CRD_W-1:0] px;
    logic [CRD_W-1:0] py;
    logic             img_end;
  } blk_t;

  // col[entry][channel], channel 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [3:0][2:0][CH_W-1:0] col;
    logic [7:0][CH_W-1:0]      alpha;
    logic [31:0]               cidx;
  } pal_t;

  // reciprocal multiplies, exact over the operand ranges used here
  function automatic logic [CH_W-1:0] div3(input logic [10:0] v);
    logic [22:0] p;
    p = 23'(v) * 23'd683;
    return p[18:11];
  endfunction

  function automatic logic [CH_W-1:0] div5(input logic [10:0] v);
    logic [24:0] p;
    p = 25'(v) * 25'd1639;
    return p[20:13];
  endfunction

  function automatic logic [CH_W-1:0] div7(input logic [10:0] v);
    logic [24:0] p;
    p = 25'(v) * 25'd2341;
    return p[21:14];
  endfunction

endpackage

// ----- rtl/core/s3tc_block_decoder_core.sv -----
// An input block passes the input stage register, the emitter's block register and the
// output register. One texel per cycle while the output is not stalled; a block sends
// only its unclipped texels (16 inside the image), a fully clipped block sends none.
// The input stage accepts the next block while the emitter works through the current one.
// Reset (rst, synchronous): format DXT1, width and height 256, block counters 0, pipeline empty.
module s3tc_block_decoder_core #(
  parameter int MAX_DIMENSION = s3tc_pkg::DEF_MAX_DIMENSION
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [127:0]               s_tdata,   // block_lo[63:0], block_hi[127:64]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // texel_x[12:0], texel_y[25:13], red[33:26], green[41:34], blue[49:42],
  // alpha[57:50], zero[63:58]
  output logic [63:0]                m_tdata,
  output logic                       m_tlast,   // last_in_block
  output logic                       m_tuser,   // last_in_image
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [s3tc_pkg::DIM_W-1:0] cfg_data
);
  import s3tc_pkg::*;

  localparam int BLOCKS = (MAX_DIMENSION + 3) / 4;
  localparam int BLK_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int XW = DIM_W + 1;
  localparam logic [XW-1:0] MAX_D = XW'(MAX_DIMENSION);

  fmt_t             texture_format;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [BLK_W-1:0] col;
  logic [BLK_W-1:0] row;
  logic [BLK_W-1:0] col_next;
  logic [BLK_W-1:0] row_next;

  logic [DIM_W-1:0] w_c;
  logic [DIM_W-1:0] h_c;
  logic [XW-1:0]    wsum;
  logic [XW-1:0]    hsum;
  logic [DIM_W-1:0] bx_cnt;
  logic [DIM_W-1:0] by_cnt;
  logic             col_end;
  logic             row_end;
  logic [3:0]       col_ok;
  logic [3:0]       row_ok;
  logic [15:0]      mask;

  logic             s_accept;
  logic             a_valid;
  logic             a_take;
  blk_t             a_blk;
  pal_t             pal;

  logic [CRD_W-1:0] texel_x;
  logic [CRD_W-1:0] texel_y;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic [CH_W-1:0]  alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_DXT1;
      image_width <= DEF_DIM;
      image_height <= DEF_DIM;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FORMAT: texture_format <= fmt_t'(cfg_data[1:0]);
        REG_WIDTH:  image_width <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_c = DIM_W'(1);
    end else if ({1'b0, image_width} > MAX_D) begin
      w_c = MAX_D[DIM_W-1:0];
    end else begin
      w_c = image_width;
    end
    if (image_height == '0) begin
      h_c = DIM_W'(1);
    end else if ({1'b0, image_height} > MAX_D) begin
      h_c = MAX_D[DIM_W-1:0];
    end else begin
      h_c = image_height;
    end
  end

  assign wsum = {1'b0, w_c} + XW'(3);
  assign hsum = {1'b0, h_c} + XW'(3);
  assign bx_cnt = DIM_W'(wsum[XW-1:2]);
  assign by_cnt = DIM_W'(hsum[XW-1:2]);
  assign col_end = (DIM_W'(col) + DIM_W'(1)) >= bx_cnt;
  assign row_end = (DIM_W'(row) + DIM_W'(1)) >= by_cnt;
  assign col_next = col_end ? '0 : col + BLK_W'(1);
  assign row_next = !col_end ? row : (row_end ? '0 : row + BLK_W'(1));

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      col_ok[j] = (XW'({col, 2'b00}) + XW'(j)) < {1'b0, w_c};
      row_ok[j] = (XW'({row, 2'b00}) + XW'(j)) < {1'b0, h_c};
    end
    for (int i = 0; i < 16; i++) begin
      mask[i] = col_ok[i % 4] && row_ok[i / 4];
    end
  end

  assign s_tready = !a_valid || a_take;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      a_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        col <= col_next;
        row <= row_next;
        a_valid <= 1'b1;
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_blk.lo <= s_tdata[63:0];
      a_blk.hi <= s_tdata[127:64];
      a_blk.fmt <= texture_format;
      a_blk.mask <= mask;
      a_blk.px <= CRD_W'({col, 2'b00});
      a_blk.py <= CRD_W'({row, 2'b00});
      a_blk.img_end <= col_end && row_end;
    end
  end

  s3tc_palette u_palette (
    .blk (a_blk),
    .pal (pal)
  );

  s3tc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (a_valid),
    .blk       (a_blk),
    .pal       (pal),
    .blk_take  (a_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .texel_x   (texel_x),
    .texel_y   (texel_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .last_blk  (m_tlast),
    .last_img  (m_tuser)
  );

  assign m_tdata = {6'b000000, alpha, blue, green, red, texel_y, texel_x};

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> a_valid)
    else $error("accepted block missing from the input stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_take |=> a_valid && $stable(a_blk))
    else $error("input stage lost or changed a waiting block");

endmodule

// ----- rtl/core/s3tc_palette.sv -----
// Colour and alpha palette builder for one compressed block.
module s3tc_palette (
  input  s3tc_pkg::blk_t blk,
  output s3tc_pkg::pal_t pal
);
  import s3tc_pkg::*;

  logic [63:0]          cb;
  logic [15:0]          c0;
  logic [15:0]          c1;
  logic [2:0][CH_W-1:0] e0;
  logic [2:0][CH_W-1:0] e1;
  logic [CH_W-1:0]      a0;
  logic [CH_W-1:0]      a1;
  logic [8:0]           mean;

  assign cb = (blk.fmt == FMT_DXT3 || blk.fmt == FMT_DXT5) ? blk.hi : blk.lo;
  assign c0 = cb[15:0];
  assign c1 = cb[31:16];
  assign e0[0] = {c0[15:11], 3'b000};
  assign e0[1] = {c0[10:5], 2'b00};
  assign e0[2] = {c0[4:0], 3'b000};
  assign e1[0] = {c1[15:11], 3'b000};
  assign e1[1] = {c1[10:5], 2'b00};
  assign e1[2] = {c1[4:0], 3'b000};
  assign a0 = blk.lo[7:0];
  assign a1 = blk.lo[15:8];

  always_comb begin
    mean = '0;
    pal.cidx = cb[63:32];
    for (int k = 0; k < 3; k++) begin
      pal.col[0][k] = e0[k];
      pal.col[1][k] = e1[k];
      if (c0 > c1) begin
        pal.col[2][k] = div3(11'({e0[k], 1'b0}) + 11'(e1[k]));
        pal.col[3][k] = div3(11'(e0[k]) + 11'({e1[k], 1'b0}));
      end else begin
        mean = 9'(e0[k]) + 9'(e1[k]);
        pal.col[2][k] = mean[8:1];
        pal.col[3][k] = '0;
      end
    end
    pal.alpha[0] = a0;
    pal.alpha[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        pal.alpha[i+1] = div7(11'(a0) * 11'(7 - i) + 11'(a1) * 11'(i));
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        pal.alpha[i+1] = div5(11'(a0) * 11'(5 - i) + 11'(a1) * 11'(i));
      end
      pal.alpha[6] = '0;
      pal.alpha[7] = 8'hFF;
    end
  end

endmodule

// ----- rtl/core/s3tc_emit.sv -----
// Texel emitter: holds one decoded block and sends its unclipped texels one per cycle unless stalled.
module s3tc_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        blk_valid,
  input  s3tc_pkg::blk_t              blk,
  input  s3tc_pkg::pal_t              pal,
  output logic                        blk_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [s3tc_pkg::CRD_W-1:0]  texel_x,
  output logic [s3tc_pkg::CRD_W-1:0]  texel_y,
  output logic [s3tc_pkg::CH_W-1:0]   red,
  output logic [s3tc_pkg::CH_W-1:0]   green,
  output logic [s3tc_pkg::CH_W-1:0]   blue,
  output logic [s3tc_pkg::CH_W-1:0]   alpha,
  output logic                        last_blk,
  output logic                        last_img
);
  import s3tc_pkg::*;

  logic [15:0]      mask;
  logic [15:0]      mask_rest;
  logic [CRD_W-1:0] px;
  logic [CRD_W-1:0] py;
  logic             img_end;
  fmt_t             fmt;
  logic [63:0]      lo;
  pal_t             pal_r;

  logic [3:0]       idx;
  logic [4:0]       coff;
  logic [5:0]       doff;
  logic [5:0]       aoff;
  logic [1:0]       ci;
  logic [3:0]       nib;
  logic [CH_W-1:0]  a_val;
  logic             out_ok;
  logic             step;
  logic             final_t;
  logic             load;

  always_comb begin
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (mask[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign mask_rest = mask & (mask - 16'd1);
  assign out_ok = !out_valid || out_ready;
  assign step = (mask != '0) && out_ok;
  assign final_t = (mask_rest == '0);
  assign load = (mask == '0) || (step && final_t);
  assign blk_take = load && blk_valid;

  assign coff = {idx, 1'b0};
  assign doff = {idx, 2'b00};
  assign aoff = 6'd16 + {2'b00, idx} * 6'd3;
  assign ci = pal_r.cidx[coff +: 2];
  assign nib = lo[doff +: 4];

  always_comb begin
    unique case (fmt)
      FMT_DXT3: a_val = {nib, nib};
      FMT_DXT5: a_val = pal_r.alpha[lo[aoff +: 3]];
      default:  a_val = 8'hFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (blk_take) begin
      mask <= blk.mask;
    end else if (step) begin
      mask <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_take) begin
      px <= blk.px;
      py <= blk.py;
      img_end <= blk.img_end;
      fmt <= blk.fmt;
      lo <= blk.lo;
      pal_r <= pal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ok) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      texel_x <= px + CRD_W'(idx[1:0]);
      texel_y <= py + CRD_W'(idx[3:2]);
      red <= pal_r.col[ci][0];
      green <= pal_r.col[ci][1];
      blue <= pal_r.col[ci][2];
      alpha <= a_val;
      last_blk <= final_t;
      last_img <= final_t && img_end;
    end
  end

  a_mask_hold: assert property (@(posedge clk) disable iff (rst)
    (mask != '0) && !out_ok |=> $stable(mask))
    else $error("texel mask changed while output stalled");

  a_img_in_blk: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_img |-> last_blk)
    else $error("image end flagged on a texel that does not end its block");

  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(mask != '0))
    else $error("output valid without a pending texel");

endmodule

// ----- bench/s3tc_block_decoder_core_tb.sv -----
// Self-checking testbench for the S3TC block decoder: directed and random blocks, all formats.
`timescale 1ns / 1ps

module s3tc_block_decoder_core_tb;
  import s3tc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEGMENT_BLOCKS = 20;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             last_blk;
    logic             last_img;
  } texel_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [127:0]     s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [63:0]      m_tdata;
  logic             m_tlast;
  logic             m_tuser;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [DIM_W-1:0] cfg_data;

  // predictor state
  fmt_t             fmt_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  int unsigned      blk_col;
  int unsigned      blk_row;
  texel_t           pending_texels[$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatch_count;
  int texels_checked;
  int blocks_sent;
  int clipped_blocks;
  int cycle_count;

  s3tc_block_decoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DEF_MAX_DIMENSION) return DEF_MAX_DIMENSION;
    return d;
  endfunction

  // Decode one block into expected texels and advance the block counters.
  function automatic void decode_block(input logic [63:0] lo, input logic [63:0] hi);
    int unsigned w, h, bx_n, by_n, x, y, a0, a1, ca, cb_ch;
    int unsigned pal[4][3];
    int unsigned apal[8];
    logic [63:0] cblk;
    logic [15:0] c0, c1;
    logic [3:0]  nib;
    logic [1:0]  ci;
    logic        col_end, row_end;
    texel_t      t;
    texel_t      blk[$];
    w = clamp_dim(width_q);
    h = clamp_dim(height_q);
    bx_n = (w + 3) / 4;
    by_n = (h + 3) / 4;
    col_end = (blk_col + 1 >= bx_n);
    row_end = (blk_row + 1 >= by_n);
    cblk = (fmt_q == FMT_DXT3 || fmt_q == FMT_DXT5) ? hi : lo;
    c0 = cblk[15:0];
    c1 = cblk[31:16];
    pal[0][0] = {c0[15:11], 3'b000};
    pal[0][1] = {c0[10:5], 2'b00};
    pal[0][2] = {c0[4:0], 3'b000};
    pal[1][0] = {c1[15:11], 3'b000};
    pal[1][1] = {c1[10:5], 2'b00};
    pal[1][2] = {c1[4:0], 3'b000};
    for (int k = 0; k < 3; k++) begin
      ca = pal[0][k];
      cb_ch = pal[1][k];
      if (c0 > c1) begin
        pal[2][k] = (2 * ca + cb_ch) / 3;
        pal[3][k] = (ca + 2 * cb_ch) / 3;
      end else begin
        pal[2][k] = (ca + cb_ch) / 2;
        pal[3][k] = 0;
      end
    end
    a0 = lo[7:0];
    a1 = lo[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    for (int i = 0; i < 16; i++) begin
      x = blk_col * 4 + (i % 4);
      y = blk_row * 4 + (i / 4);
      if (x >= w || y >= h) continue;
      ci = cblk[32 + 2 * i +: 2];
      t.x = x[CRD_W-1:0];
      t.y = y[CRD_W-1:0];
      t.red = 8'(pal[ci][0]);
      t.green = 8'(pal[ci][1]);
      t.blue = 8'(pal[ci][2]);
      case (fmt_q)
        FMT_DXT3: begin
          nib = lo[4 * i +: 4];
          t.alpha = {nib, nib};
        end
        FMT_DXT5: t.alpha = 8'(apal[lo[16 + 3 * i +: 3]]);
        default:  t.alpha = 8'hFF;
      endcase
      t.last_blk = 1'b0;
      t.last_img = 1'b0;
      blk.push_back(t);
    end
    if (blk.size() > 0) begin
      blk[blk.size() - 1].last_blk = 1'b1;
      blk[blk.size() - 1].last_img = col_end && row_end;
    end else begin
      clipped_blocks++;
    end
    foreach (blk[j]) pending_texels.push_back(blk[j]);
    if (col_end) begin
      blk_col = 0;
      blk_row = row_end ? 0 : blk_row + 1;
    end else begin
      blk_col = blk_col + 1;
    end
  endfunction

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    decode_block(lo, hi);
    blocks_sent++;
    s_tvalid <= 1'b1;
    s_tdata <= {hi, lo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DIM_W-1:0] fmt_val, input logic [DIM_W-1:0] w_val,
                            input logic [DIM_W-1:0] h_val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_FORMAT;
    cfg_data <= fmt_val;
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data <= w_val;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_q = fmt_t'(fmt_val[1:0]);
    width_q = w_val;
    height_q = h_val;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 8) return DIM_W'($urandom_range(1));
    if (r < 90) return DIM_W'($urandom_range(40, 1));
    return DIM_W'($urandom_range(16383, 8000));
  endfunction

  task automatic flag_mismatch(input string what, input texel_t want, input texel_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("ERROR %s: expected x=%0d y=%0d rgba=%02h%02h%02h%02h last=%b%b, got x=%0d y=%0d rgba=%02h%02h%02h%02h last=%b%b",
               what, want.x, want.y, want.red, want.green, want.blue, want.alpha,
               want.last_blk, want.last_img, got.x, got.y, got.red, got.green, got.blue,
               got.alpha, got.last_blk, got.last_img);
  endtask

  // output side: random stall and per-transaction check
  always @(posedge clk) begin
    texel_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
      if (m_tvalid && m_tready) begin
        got = {m_tdata[12:0], m_tdata[25:13], m_tdata[33:26], m_tdata[41:34],
               m_tdata[49:42], m_tdata[57:50], m_tlast, m_tuser};
        texels_checked++;
        if (pending_texels.size() == 0) begin
          flag_mismatch("unexpected texel", '0, got);
        end else begin
          want = pending_texels.pop_front();
          if (got !== want) flag_mismatch("texel mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_dxt1_palettes();
    send_block(64'h0, rand64());
    send_block(64'hFFFF_FFFF_FFFF_FFFF, rand64());
    send_block(64'hE4E4_E4E4_0000_FFFF, rand64());
    send_block(64'hE4E4_E4E4_F800_07E0, rand64());
  endtask

  task automatic test_dxt3_alpha();
    write_regs(FMT_DXT3, 14'd256, 14'd256);
    send_block(64'hFEDC_BA98_7654_3210, 64'hE4E4_E4E4_001F_FFE0);
    send_block(64'h0, rand64());
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
  endtask

  task automatic test_dxt5_alpha();
    write_regs(FMT_DXT5, 14'd256, 14'd256);
    send_block(64'hFAC6_88FA_C688_00FF, rand64());
    send_block(64'hFAC6_88FA_C688_FF00, rand64());
    send_block(64'hFAC6_88FA_C688_8080, 64'h1B1B_1B1B_AAAA_AAAA);
  endtask

  task automatic test_dimensions();
    // zero size acts as one texel, reserved format decodes as DXT1
    write_regs(FMT_RSVD, 14'd0, 14'd0);
    send_block(rand64(), rand64());
    send_block(rand64(), rand64());
    write_regs(FMT_DXT5, 14'd6, 14'd5);
    repeat (4) send_block(rand64(), rand64());
    // upper format bits ignored, oversized dimensions saturate
    write_regs(14'h3FFC | FMT_DXT3, 14'd16383, 14'd16383);
    repeat (2) send_block(rand64(), rand64());
    write_regs(FMT_DXT1, 14'd8192, 14'd4);
    repeat (3) send_block(rand64(), rand64());
    // shrink mid-image: next block lies outside and is fully clipped
    write_regs(FMT_DXT1, 14'd4, 14'd4);
    repeat (3) send_block(rand64(), rand64());
  endtask

  task automatic run_random_phase(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    repeat (4) begin
      write_regs(DIM_W'($urandom_range(3)), pick_dim(), pick_dim());
      repeat (SEGMENT_BLOCKS) send_block(rand64(), rand64());
    end
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FORMAT;
    cfg_data <= '0;
    fmt_q = FMT_DXT1;
    width_q = DEF_DIM;
    height_q = DEF_DIM;
    blk_col = 0;
    blk_row = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    blocks_sent = 0;
    clipped_blocks = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_dxt1_palettes();
    test_dxt3_alpha();
    test_dxt5_alpha();
    test_dimensions();
    run_random_phase(0, 0);
    run_random_phase(69, 0);
    run_random_phase(0, 69);
    run_random_phase(37, 37);
    wait_idle();

    $display("Sent %0d blocks (%0d fully clipped), checked %0d texels", blocks_sent,
             clipped_blocks, texels_checked);
    $display("Covered DXT1/DXT3/DXT5/reserved formats, sizes 0..16383, with and without stalls");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching transactions", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/s3tc_pkg.sv
rtl/core/s3tc_palette.sv
rtl/core/s3tc_emit.sv
rtl/core/s3tc_block_decoder_core.sv
bench/s3tc_block_decoder_core_tb.sv
